// File: src/flha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package flha_pkg;

  localparam int ArenaWords = 128;
  localparam int AddrW      = 7;
  localparam int SizeW      = 16;
  localparam int Hdr        = 2;

  // one header word: size, next link, link-valid
  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [AddrW-1:0] next;
    logic             has_next;
  } hdr_t;

  localparam int HdrW = $bits(hdr_t);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_A_RD,
    ST_A_WAIT,
    ST_A_CHK,
    ST_A_SEL,
    ST_A_RDB,
    ST_A_WTB,
    ST_A_SPLIT,
    ST_A_RDP,
    ST_A_UNL,
    ST_F_RD,
    ST_F_WAIT,
    ST_F_CHK,
    ST_F_RDH,
    ST_F_WTH,
    ST_F_LINK,
    ST_F_RDN,
    ST_F_WTN,
    ST_F_MRGN,
    ST_F_RDP,
    ST_F_WTP,
    ST_F_MRGP,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: src/flha_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module flha_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/free_list_heap_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// An allocate walks the free list node by node, stopping at the first fit unless
// best fit is set; a free walks it up to the ordered place of the block.
// One item at a time: busy is high from acceptance until the done strobe.
// The single header RAM port pair (one read, one write a cycle) sets the rate.
// Reset: a clearing pass writes the whole-arena header into word 0 and clears the rest, busy meanwhile.
// The receiver cannot stall: each result is shown for one cycle with done.
module free_list_heap_allocator_core
  import flha_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       cmd,
  input  wire logic [6:0] size_words,
  input  wire logic [6:0] block_addr,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  output logic            done,
  output logic            ok,
  output logic [6:0]      data_addr,
  output logic [7:0]      remain_words,
  output logic [6:0]      live_count
);

  state_t state, state_next;

  logic fit_mode;
  logic [AddrW-1:0] list_head, list_head_next;
  logic head_valid, head_valid_next;
  logic [SizeW-1:0] free_total, free_total_next;
  logic [6:0] outstanding, outstanding_next;

  logic [AddrW-1:0] req, req_next;
  logic [AddrW:0]   haddr, haddr_next;
  logic [AddrW-1:0] cur, cur_next, prev, prev_next;
  logic cvalid, cvalid_next, has_prev, has_prev_next;
  logic [AddrW-1:0] best, best_next, bprev, bprev_next;
  logic bhas_prev, bhas_prev_next, found, found_next;
  logic [SizeW-1:0] bsize, bsize_next;
  logic [AddrW:0]   steps, steps_next;
  hdr_t hb, hb_next;          // held header of node of interest
  hdr_t ph, ph_next;          // held prev header
  logic [SizeW-1:0] msize, msize_next;
  logic [AddrW-1:0] nx, nx_next;
  logic r_ok, r_ok_next;
  logic [AddrW-1:0] r_addr, r_addr_next;

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  hdr_t wdata, rdata;
  logic [HdrW-1:0] rdata_raw;

  flha_ram #(.Width(HdrW), .Depth(ArenaWords)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw)
  );
  assign rdata = hdr_t'(rdata_raw);

  // shared adder/compare operands
  logic [SizeW+1:0] split_end, sum_a;
  logic do_split;
  assign split_end = (SizeW+2)'(best) + (SizeW+2)'(Hdr) + (SizeW+2)'(req);
  assign do_split = ({2'b0, bsize} > (SizeW+2)'(req) + (SizeW+2)'(Hdr)) &&
                    (split_end < (SizeW+2)'(ArenaWords));

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= 1'b0;
    end else if (cfg_we) begin
      fit_mode <= cfg_wdata;
    end
  end

  // state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      list_head   <= '0;
      head_valid  <= 1'b1;
      free_total  <= SizeW'(ArenaWords - Hdr);
      outstanding <= '0;
      steps       <= '0;
    end else begin
      state       <= state_next;
      list_head   <= list_head_next;
      head_valid  <= head_valid_next;
      free_total  <= free_total_next;
      outstanding <= outstanding_next;
      steps       <= steps_next;
    end
    req <= req_next; haddr <= haddr_next; cur <= cur_next; prev <= prev_next;
    cvalid <= cvalid_next; has_prev <= has_prev_next; best <= best_next;
    bprev <= bprev_next; bhas_prev <= bhas_prev_next; found <= found_next;
    bsize <= bsize_next; hb <= hb_next; ph <= ph_next; msize <= msize_next;
    nx <= nx_next; r_ok <= r_ok_next; r_addr <= r_addr_next;
  end

  // sequencer
  always_comb begin
    state_next = state;
    list_head_next = list_head; head_valid_next = head_valid;
    free_total_next = free_total; outstanding_next = outstanding;
    req_next = req; haddr_next = haddr; cur_next = cur; prev_next = prev;
    cvalid_next = cvalid; has_prev_next = has_prev; best_next = best;
    bprev_next = bprev; bhas_prev_next = bhas_prev; found_next = found;
    bsize_next = bsize; steps_next = steps; hb_next = hb; ph_next = ph;
    msize_next = msize; nx_next = nx; r_ok_next = r_ok; r_addr_next = r_addr;
    we = 1'b0; waddr = cur; wdata = '0; raddr = cur;
    sum_a = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_CLEAR: begin
        // sweep header store to reset image
        we = 1'b1;
        waddr = steps[AddrW-1:0];
        wdata = '0;
        if (steps == '0) wdata.size = SizeW'(ArenaWords - Hdr);
        steps_next = steps + 1'b1;
        if (steps == (AddrW+1)'(ArenaWords - 1)) begin
          steps_next = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          req_next = size_words;
          haddr_next = {1'b0, block_addr} - (AddrW+1)'(Hdr);
          cur_next = list_head; cvalid_next = head_valid;
          prev_next = '0; has_prev_next = 1'b0; found_next = 1'b0;
          bsize_next = '0; steps_next = '0; r_ok_next = 1'b0; r_addr_next = '0;
          if (cmd == CMD_ALLOC) begin
            state_next = (SizeW'(size_words) > free_total) ? ST_DONE : ST_A_RD;
          end else begin
            state_next = (block_addr < AddrW'(Hdr)) ? ST_DONE : ST_F_RD;
          end
        end
      end
      // allocate: walk the list
      ST_A_RD: begin
        if (!cvalid || steps == (AddrW+1)'(ArenaWords)) begin
          state_next = found ? ST_A_SEL : ST_DONE;
        end else begin
          raddr = cur;
          state_next = ST_A_WAIT;
        end
      end
      ST_A_WAIT: begin
        state_next = ST_A_CHK;
      end
      ST_A_CHK: begin
        steps_next = steps + 1'b1;
        prev_next = cur; has_prev_next = 1'b1;
        cvalid_next = rdata.has_next; cur_next = rdata.next;
        state_next = ST_A_RD;
        if (rdata.size >= SizeW'(req) && (!found || rdata.size < bsize)) begin
          found_next = 1'b1; best_next = cur; bsize_next = rdata.size;
          bprev_next = prev; bhas_prev_next = has_prev;
          if (!fit_mode) state_next = ST_A_SEL;
        end
      end
      ST_A_SEL: begin
        raddr = best;
        state_next = ST_A_RDB;
      end
      ST_A_RDB: begin
        hb_next = rdata;
        state_next = ST_A_WTB;
      end
      ST_A_WTB: begin
        msize_next = bsize;
        if (do_split) begin
          // write remainder header after the taken part
          we = 1'b1;
          waddr = split_end[AddrW-1:0];
          wdata.size = bsize - SizeW'(req) - SizeW'(Hdr);
          wdata.next = hb.next;
          wdata.has_next = hb.has_next;
          msize_next = SizeW'(req) + SizeW'(Hdr);
        end
        state_next = ST_A_SPLIT;
      end
      ST_A_SPLIT: begin
        if (do_split) begin
          // best shrinks to req and links to the remainder
          we = 1'b1; waddr = best;
          wdata.size = SizeW'(req);
          wdata.next = split_end[AddrW-1:0];
          wdata.has_next = 1'b1;
          hb_next.next = split_end[AddrW-1:0];
          hb_next.has_next = 1'b1;
        end
        state_next = ST_A_RDP;
      end
      ST_A_RDP: begin
        // fetch prev header after the split writes
        raddr = bprev;
        state_next = ST_A_UNL;
      end
      ST_A_UNL: begin
        // unlink best from prev or from head
        if (bhas_prev) begin
          we = 1'b1; waddr = bprev;
          wdata = rdata; wdata.next = hb.next; wdata.has_next = hb.has_next;
        end else begin
          list_head_next = hb.next; head_valid_next = hb.has_next;
        end
        free_total_next = free_total - msize;
        outstanding_next = outstanding + 1'b1;
        r_ok_next = 1'b1;
        r_addr_next = best + AddrW'(Hdr);
        state_next = ST_DONE;
      end
      // free: find ordered place
      ST_F_RD: begin
        if (haddr[AddrW]) begin
          state_next = ST_DONE;
        end else if (!cvalid || steps == (AddrW+1)'(ArenaWords) ||
                     haddr[AddrW-1:0] <= cur) begin
          if (cvalid && cur == haddr[AddrW-1:0]) begin
            state_next = ST_DONE;
          end else begin
            raddr = haddr[AddrW-1:0];
            state_next = ST_F_RDH;
          end
        end else begin
          raddr = cur;
          state_next = ST_F_WAIT;
        end
      end
      ST_F_WAIT: begin
        state_next = ST_F_CHK;
      end
      ST_F_CHK: begin
        steps_next = steps + 1'b1;
        prev_next = cur; has_prev_next = 1'b1; ph_next = rdata;
        cvalid_next = rdata.has_next; cur_next = rdata.next;
        state_next = ST_F_RD;
      end
      ST_F_RDH: begin
        raddr = haddr[AddrW-1:0];
        state_next = ST_F_WTH;
      end
      ST_F_WTH: begin
        hb_next = rdata;
        state_next = ST_F_LINK;
      end
      ST_F_LINK: begin
        // link h in after prev or at head
        if (has_prev) begin
          hb_next.next = ph.next; hb_next.has_next = ph.has_next;
          we = 1'b1; waddr = prev;
          wdata = ph; wdata.next = haddr[AddrW-1:0]; wdata.has_next = 1'b1;
          ph_next.next = haddr[AddrW-1:0]; ph_next.has_next = 1'b1;
        end else begin
          hb_next.next = list_head; hb_next.has_next = head_valid;
          list_head_next = haddr[AddrW-1:0]; head_valid_next = 1'b1;
        end
        msize_next = hb.size;
        free_total_next = free_total + hb.size;
        state_next = ST_F_RDN;
      end
      ST_F_RDN: begin
        raddr = hb.next;
        nx_next = hb.next;
        state_next = ST_F_WTN;
      end
      ST_F_WTN: begin
        raddr = nx;
        state_next = ST_F_MRGN;
      end
      ST_F_MRGN: begin
        sum_a = (SizeW+2)'(haddr[AddrW-1:0]) + (SizeW+2)'(msize) + (SizeW+2)'(Hdr);
        if (hb.has_next && sum_a == (SizeW+2)'(nx)) begin
          hb_next.next = rdata.next; hb_next.has_next = rdata.has_next;
          msize_next = msize + SizeW'(Hdr) + rdata.size;
          free_total_next = free_total + SizeW'(Hdr);
        end
        state_next = ST_F_RDP;
      end
      ST_F_RDP: begin
        // commit h header before the prev merge check
        we = 1'b1; waddr = haddr[AddrW-1:0];
        wdata = hb; wdata.size = msize;
        state_next = ST_F_MRGP;
      end
      ST_F_MRGP: begin
        sum_a = (SizeW+2)'(prev) + (SizeW+2)'(ph.size) + (SizeW+2)'(Hdr);
        if (has_prev && sum_a == (SizeW+2)'(haddr[AddrW-1:0])) begin
          we = 1'b1; waddr = prev;
          wdata.size = ph.size + msize + SizeW'(Hdr);
          wdata.next = hb.next; wdata.has_next = hb.has_next;
          free_total_next = free_total + SizeW'(Hdr);
        end
        if (outstanding != '0) outstanding_next = outstanding - 1'b1;
        r_ok_next = 1'b1;
        state_next = ST_DONE;
      end
      ST_F_WTP: begin
        state_next = ST_F_MRGP;
      end
      ST_DONE: begin
        done = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign ok = r_ok;
  assign data_addr = r_addr;
  assign remain_words = free_total[7:0];
  assign live_count = outstanding;

endmodule
`default_nettype wire

// File: tb/sv/tb_free_list_heap_allocator_core.sv
`timescale 1ns / 1ps
module tb_free_list_heap_allocator_core
  import flha_pkg::*;
();

  typedef enum logic {OP_ITEM, OP_SET_FIT} op_kind_t;

  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  typedef struct {
    op_kind_t   kind;
    logic       cmd;
    logic [6:0] size;
    logic [6:0] addr;
    logic       fit;
  } op_t;

  typedef struct {
    logic       ok;
    logic [6:0] data_addr;
    logic [7:0] remain;
    logic [6:0] live;
  } outcome_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       cmd = CMD_ALLOC;
  logic [6:0] size_words = '0;
  logic [6:0] block_addr = '0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       busy, done, ok;
  logic [6:0] data_addr, live_count;
  logic [7:0] remain_words;

  free_list_heap_allocator_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .size_words(size_words), .block_addr(block_addr),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .ok(ok),
    .data_addr(data_addr), .remain_words(remain_words), .live_count(live_count)
  );

  always #4 clk = ~clk;

  op_t      op_q[$];
  outcome_t want_q[$];
  logic [6:0] live_addrs[$];
  int       errors = 0;
  logic     took = 1'b0;

  // heap mirror
  logic [15:0] hsize[ArenaWords];
  int          hnext[ArenaWords];
  bit          hhas[ArenaWords];
  int          head;
  bit          head_ok;
  logic [15:0] free_words;
  logic [6:0]  live_allocs;
  logic        fit_sel;

  task automatic report(input string what, input int got, input int exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  function automatic void heap_reset();
    for (int i = 0; i < ArenaWords; i++) begin
      hsize[i] = '0;
      hnext[i] = 0;
      hhas[i] = 0;
    end
    hsize[0] = ArenaWords - Hdr;
    head = 0;
    head_ok = 1;
    free_words = ArenaWords - Hdr;
    live_allocs = '0;
    fit_sel = FIT_FIRST;
  endfunction

  function automatic void drop_node(bit has_prev, int prv, int node);
    if (has_prev) begin
      hnext[prv] = hnext[node];
      hhas[prv] = hhas[node];
    end else begin
      head = hnext[node];
      head_ok = hhas[node];
    end
  endfunction

  function automatic bit heap_alloc(input int req, output int addr);
    int cur, prev, bprev, best, bsize, s, take, n;
    bit valid, has_prev, found, bhas_prev;
    cur = head; prev = 0; bprev = 0; best = 0; bsize = 0;
    valid = head_ok; has_prev = 0; found = 0; bhas_prev = 0;
    addr = 0;
    if (req > free_words) return 0;
    for (int steps = 0; valid && steps < ArenaWords; steps++) begin
      s = hsize[cur];
      if (s >= req && (!found || s < bsize)) begin
        found = 1; best = cur; bsize = s; bprev = prev; bhas_prev = has_prev;
        if (fit_sel == FIT_FIRST) break;
      end
      prev = cur; has_prev = 1;
      valid = hhas[cur];
      cur = hnext[cur];
    end
    if (!found) return 0;
    take = bsize;
    n = best + Hdr + req;
    // split off the tail when it can hold a header of its own
    if (bsize > req + Hdr && n < ArenaWords) begin
      hsize[n] = bsize - req - Hdr;
      hnext[n] = hnext[best];
      hhas[n] = hhas[best];
      hnext[best] = n;
      hhas[best] = 1;
      hsize[best] = req;
      take = req + Hdr;
    end
    drop_node(bhas_prev, bprev, best);
    free_words = free_words - take;
    live_allocs = live_allocs + 1;
    addr = best + Hdr;
    return 1;
  endfunction

  function automatic bit heap_free(input int a);
    int h, cur, prev, msize, nx, nsize, psize;
    bit valid, has_prev;
    cur = head; prev = 0; valid = head_ok; has_prev = 0;
    if (a < Hdr) return 0;
    h = a - Hdr;
    if (h >= ArenaWords) return 0;
    // find the ordered place
    for (int steps = 0; valid && steps < ArenaWords; steps++) begin
      if (h <= cur) break;
      prev = cur; has_prev = 1;
      valid = hhas[cur];
      cur = hnext[cur];
    end
    if (valid && cur == h) return 0;
    if (has_prev) begin
      hnext[h] = hnext[prev];
      hhas[h] = hhas[prev];
      hnext[prev] = h;
      hhas[prev] = 1;
    end else begin
      hnext[h] = head;
      hhas[h] = head_ok;
      head = h;
      head_ok = 1;
    end
    msize = hsize[h];
    free_words = free_words + msize;
    // merge with the following block
    if (hhas[h]) begin
      nx = hnext[h];
      if (h + msize + Hdr == nx) begin
        nsize = hsize[nx];
        drop_node(1, h, nx);
        msize = (msize + Hdr + nsize) & 16'hFFFF;
        hsize[h] = msize;
        free_words = free_words + Hdr;
      end
    end
    // merge with the preceding block
    if (has_prev) begin
      psize = hsize[prev];
      if (prev + psize + Hdr == h) begin
        drop_node(1, prev, h);
        hsize[prev] = psize + msize + Hdr;
        free_words = free_words + Hdr;
      end
    end
    if (live_allocs > 0) live_allocs = live_allocs - 1;
    return 1;
  endfunction

  // monitor: check results, predict accepted items
  always @(posedge clk) begin
    outcome_t got, exp;
    int addr;
    bit good;
    took <= !rst && start && !busy;
    if (!rst) begin
      if (done) begin
        got = '{ok, data_addr, remain_words, live_count};
        if (want_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          exp = want_q.pop_front();
          if (got.ok !== exp.ok) report("ok", got.ok, exp.ok);
          if (got.data_addr !== exp.data_addr) report("data_addr", got.data_addr, exp.data_addr);
          if (got.remain !== exp.remain) report("remain_words", got.remain, exp.remain);
          if (got.live !== exp.live) report("live_count", got.live, exp.live);
        end
      end
      if (start && !busy) begin
        addr = 0;
        if (cmd == CMD_ALLOC) begin
          good = heap_alloc(size_words, addr);
          if (good) live_addrs.push_back(addr[6:0]);
        end else begin
          good = heap_free(block_addr);
          if (good) begin
            foreach (live_addrs[i]) begin
              if (live_addrs[i] == block_addr) begin
                live_addrs.delete(i);
                break;
              end
            end
          end
        end
        exp = '{good, addr[6:0], free_words[7:0], live_allocs};
        want_q.push_back(exp);
      end
      if (cfg_we) fit_sel = cfg_wdata;
    end
  end

  // driver: one item at a time from the pending queue
  int gap = 0;
  int settle = 0;
  always @(negedge clk) begin
    logic n_start, n_cmd, n_we, n_wd;
    logic [6:0] n_size, n_addr;
    op_t op;
    n_start = start; n_cmd = cmd; n_size = size_words; n_addr = block_addr;
    n_we = 1'b0; n_wd = cfg_wdata;
    if (rst) begin
      n_start = 1'b0;
    end else if (!(start && !took)) begin
      n_start = 1'b0;
      if (gap > 0) begin
        gap--;
      end else if (op_q.size() > 0) begin
        op = op_q[0];
        if (op.kind == OP_ITEM) begin
          n_start = 1'b1;
          n_cmd = op.cmd;
          n_size = op.size;
          n_addr = op.addr;
          void'(op_q.pop_front());
          gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 5);
        end else if (want_q.size() == 0 && !busy) begin
          // register write only once the core has gone quiet
          if (settle >= 4) begin
            n_we = 1'b1;
            n_wd = op.fit;
            void'(op_q.pop_front());
            settle = 0;
          end else begin
            settle++;
          end
        end
      end
    end
    start <= n_start;
    cmd <= n_cmd;
    size_words <= n_size;
    block_addr <= n_addr;
    cfg_we <= n_we;
    cfg_wdata <= n_wd;
  end

  task automatic push_item(input logic c, input int sz, input int ad);
    op_t op;
    op = '{OP_ITEM, c, sz[6:0], ad[6:0], 1'b0};
    op_q.push_back(op);
  endtask

  task automatic push_fit(input logic f);
    op_t op;
    op = '{OP_SET_FIT, CMD_ALLOC, 7'd0, 7'd0, f};
    op_q.push_back(op);
  endtask

  task automatic wait_quiet();
    do @(posedge clk); while (op_q.size() != 0 || want_q.size() != 0 || start);
  endtask

  initial begin
    logic [6:0] pool[$];
    int k, sel;
    heap_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: whole arena, null frees, double frees, fit policies
    push_fit(FIT_FIRST);
    push_item(CMD_ALLOC, 127, 0);
    push_item(CMD_ALLOC, 126, 127);
    push_item(CMD_ALLOC, 0, 0);
    push_item(CMD_FREE, 0, 2);
    push_item(CMD_FREE, 127, 0);
    push_item(CMD_FREE, 0, 1);
    push_item(CMD_FREE, 0, 2);
    push_item(CMD_ALLOC, 0, 0);
    push_item(CMD_ALLOC, 10, 0);
    push_item(CMD_ALLOC, 4, 0);
    push_item(CMD_ALLOC, 20, 0);
    push_item(CMD_ALLOC, 3, 0);
    push_item(CMD_FREE, 0, 4);
    push_item(CMD_FREE, 0, 4);
    push_item(CMD_FREE, 0, 22);
    push_item(CMD_FREE, 0, 2);
    push_item(CMD_ALLOC, 2, 0);
    wait_quiet();
    push_fit(FIT_BEST);
    push_item(CMD_ALLOC, 2, 0);
    push_item(CMD_ALLOC, 88, 0);
    push_item(CMD_FREE, 0, 16);
    push_item(CMD_FREE, 0, 127);
    push_item(CMD_ALLOC, 127, 127);
    wait_quiet();

    // random bursts, frees drawn from the current live set
    for (int burst = 0; burst < 50; burst++) begin
      if (burst % 8 == 0) push_fit(burst % 16 == 0 ? FIT_FIRST : FIT_BEST);
      pool = live_addrs;
      for (int i = 0; i < 10; i++) begin
        k = $urandom_range(0, 99);
        if (k < 45) begin
          sel = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 15);
          push_item(CMD_ALLOC, sel, $urandom_range(0, 127));
        end else if (k < 85 && pool.size() > 0) begin
          sel = $urandom_range(0, pool.size() - 1);
          push_item(CMD_FREE, $urandom_range(0, 127), pool[sel]);
          pool.delete(sel);
        end else begin
          // stray frees, null and bogus addresses
          push_item(CMD_FREE, $urandom_range(0, 127), $urandom_range(0, 127));
        end
      end
      wait_quiet();
    end

    repeat (500) @(posedge clk);
    if (errors == 0 && want_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
src/flha_pkg.sv
src/flha_ram.sv
src/free_list_heap_allocator_core.sv
tb/sv/tb_free_list_heap_allocator_core.sv
